>>> rtl/sscfe_pkg.sv
// ============================================================================
// sscfe_pkg
// Shared types, byte codes and command tables for the serial setting
// command frame engine.
// ============================================================================
`default_nettype none

package sscfe_pkg;

    localparam logic [7:0] HDR_BYTE  = 8'hFF;
    localparam logic [7:0] TAIL_BYTE = 8'hFE;
    localparam logic [7:0] CMD_MAX   = 8'd8;
    localparam logic [3:0] CMD_TEST  = 4'd8;

    localparam logic [2:0] CMD_GET_ADDR0  = 3'd0;
    localparam logic [2:0] CMD_SET_ADDR0  = 3'd1;
    localparam logic [2:0] CMD_GET_ADDR1  = 3'd2;
    localparam logic [2:0] CMD_SET_ADDR1  = 3'd3;
    localparam logic [2:0] CMD_GET_PREFIX = 3'd4;
    localparam logic [2:0] CMD_SET_PREFIX = 3'd5;
    localparam logic [2:0] CMD_GET_CHAN   = 3'd6;
    localparam logic [2:0] CMD_SET_CHAN   = 3'd7;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [63:0] payload;
    } cmd_rec_t;

    // Payload length for commands 0..8.
    function automatic logic [3:0] pay_len(input logic [3:0] cmd);
        logic [3:0] len;
        begin
            case (cmd)
                4'd1, 4'd3: len = 4'd4;
                4'd5:       len = 4'd8;
                4'd7:       len = 4'd1;
                default:    len = 4'd0;
            endcase
            return len;
        end
    endfunction

    // Value size in bytes of the setting addressed by a command.
    function automatic logic [3:0] val_size(input logic [2:0] cmd);
        logic [3:0] size;
        begin
            case (cmd[2:1])
                2'd0, 2'd1: size = 4'd4;
                2'd2:       size = 4'd8;
                default:    size = 4'd1;
            endcase
            return size;
        end
    endfunction

endpackage

`default_nettype wire

>>> rtl/serial_setting_command_frame_engine.sv
// ============================================================================
// serial_setting_command_frame_engine
// Settings command frame engine for a received serial byte stream.
// ============================================================================
// Usage:
//   Input channel: in_valid / in_stall / rx_byte, one received byte per item.
//   Output channel: out_valid / out_stall / tx_byte, tx_last, persist_request,
//   one response byte per item; tx_last marks the closing 0xFE and
//   persist_request rides on it when a set command changed a setting.
//   The parser takes one byte per cycle while the queue is not full. A good
//   frame ending in 0xFE queues its command; an idle responder pops it, and
//   the command goes through the queue, the busy flag and the output
//   register before its first byte. A response of size+4 bytes (5 to 12)
//   streams one byte per cycle unless stalled; its tail frees the responder.
//   A two-entry queue decouples parser and responder; in_stall rises only
//   when that queue is full. A stalled output holds its byte; the responder
//   and then the queue back up behind it.
//   Reset clears the frame state, the queue, the output valid flag and the
//   stored addresses, prefix and channel to zero.
// ============================================================================
`default_nettype none

module serial_setting_command_frame_engine
    import sscfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      tx_byte,
    output logic            tx_last,
    output logic            persist_request
);

    cmd_rec_t push_rec;
    cmd_rec_t head_rec;
    logic     q_push;
    logic     q_full;
    logic     q_pop;
    logic     q_not_empty;

    sscfe_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .rx_byte  (rx_byte),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_rec    (push_rec)
    );

    sscfe_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (push_rec),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_rec  (head_rec)
    );

    sscfe_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_not_empty     (q_not_empty),
        .q_head          (head_rec),
        .q_pop           (q_pop),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .tx_byte         (tx_byte),
        .tx_last         (tx_last),
        .persist_request (persist_request)
    );

endmodule

`default_nettype wire

>>> rtl/sscfe_front.sv
// ============================================================================
// sscfe_front
// Frame parser: tracks header, command, payload and tail of received bytes
// and queues each complete get or set command.
// ============================================================================
`default_nettype none

module sscfe_front
    import sscfe_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       q_full,
    output logic            q_push,
    output cmd_rec_t        q_rec
);

    logic        in_frame_reg, in_frame_next;
    logic [3:0]  pos_reg, pos_next;
    logic [3:0]  len_reg, len_next;
    logic [3:0]  cmd_reg, cmd_next;
    logic [63:0] buf_reg, buf_next;
    logic [3:0]  pos_m1;
    logic        accept;

    assign in_stall    = q_full;
    assign accept      = in_valid && !q_full;
    assign pos_m1      = pos_reg - 4'd1;
    assign q_rec.cmd     = cmd_reg[2:0];
    assign q_rec.payload = buf_reg;

    always_comb
    begin
        in_frame_next = in_frame_reg;
        pos_next      = pos_reg;
        len_next      = len_reg;
        cmd_next      = cmd_reg;
        buf_next      = buf_reg;
        q_push        = 1'b0;
        if (accept)
        begin
            if (!in_frame_reg)
            begin
                if (rx_byte == HDR_BYTE)
                begin
                    in_frame_next = 1'b1;
                    buf_next      = '0;
                end
                pos_next = 4'd0;
                len_next = 4'd0;
            end
            else if (pos_reg == 4'd0)
            begin
                if (rx_byte > CMD_MAX)
                begin
                    in_frame_next = 1'b0;
                    len_next      = 4'd0;
                end
                else
                begin
                    cmd_next = rx_byte[3:0];
                    len_next = pay_len(rx_byte[3:0]);
                    pos_next = 4'd1;
                end
            end
            else if (pos_m1 >= len_reg)
            begin
                if (rx_byte == TAIL_BYTE && cmd_reg != CMD_TEST)
                begin
                    q_push = 1'b1;
                end
                in_frame_next = 1'b0;
                pos_next      = 4'd0;
            end
            else
            begin
                buf_next[{pos_m1[2:0], 3'b000} +: 8] = rx_byte;
                pos_next = pos_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
            pos_reg      <= 4'd0;
            len_reg      <= 4'd0;
            cmd_reg      <= 4'd0;
            buf_reg      <= '0;
        end
        else
        begin
            in_frame_reg <= in_frame_next;
            pos_reg      <= pos_next;
            len_reg      <= len_next;
            cmd_reg      <= cmd_next;
            buf_reg      <= buf_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sscfe_queue.sv
// ============================================================================
// sscfe_queue
// Two-entry command queue between the frame parser and the responder.
// ============================================================================
`default_nettype none

module sscfe_queue
    import sscfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire cmd_rec_t push_rec,
    output logic          full,
    input  wire logic     pop,
    output logic          not_empty,
    output cmd_rec_t      head_rec
);

    cmd_rec_t   entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign head_rec  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sscfe_back.sv
// ============================================================================
// sscfe_back
// Responder: holds the settings, applies set commands and streams each
// response frame through an output register.
// ============================================================================
`default_nettype none

module sscfe_back
    import sscfe_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     q_not_empty,
    input  wire cmd_rec_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  wire logic     out_stall,
    output logic [7:0]    tx_byte,
    output logic          tx_last,
    output logic          persist_request
);

    logic [31:0] addr0_reg, addr0_next;
    logic [31:0] addr1_reg, addr1_next;
    logic [63:0] prefix_reg, prefix_next;
    logic [7:0]  chan_reg, chan_next;

    logic        busy_reg, busy_next;
    logic [3:0]  k_reg, k_next;
    logic [2:0]  cmd_reg, cmd_next;
    logic [3:0]  size_reg, size_next;
    logic [63:0] val_reg, val_next;
    logic        changed_reg, changed_next;

    logic        out_valid_reg, out_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        tx_last_reg, tx_last_next;
    logic        persist_reg, persist_next;

    logic        out_load;
    logic [63:0] new_val;
    logic [63:0] old_val;
    logic [3:0]  head_size;
    logic [3:0]  last_k;

    assign out_valid       = out_valid_reg;
    assign tx_byte         = tx_byte_reg;
    assign tx_last         = tx_last_reg;
    assign persist_request = persist_reg;

    assign out_load  = !out_valid_reg || !out_stall;
    assign q_pop     = !busy_reg && q_not_empty;
    assign head_size = val_size(q_head.cmd);
    assign last_k    = size_reg + 4'd3;

    always_comb
    begin
        case (q_head.cmd[2:1])
            2'd0:    old_val = {32'd0, addr0_reg};
            2'd1:    old_val = {32'd0, addr1_reg};
            2'd2:    old_val = prefix_reg;
            default: old_val = {56'd0, chan_reg};
        endcase
        case (q_head.cmd[2:1])
            2'd0, 2'd1: new_val = {32'd0, q_head.payload[31:0]};
            2'd2:       new_val = q_head.payload;
            default:    new_val = {56'd0, q_head.payload[7:0]};
        endcase
    end

    always_comb
    begin
        addr0_next     = addr0_reg;
        addr1_next     = addr1_reg;
        prefix_next    = prefix_reg;
        chan_next      = chan_reg;
        busy_next      = busy_reg;
        k_next         = k_reg;
        cmd_next       = cmd_reg;
        size_next      = size_reg;
        val_next       = val_reg;
        changed_next   = changed_reg;
        out_valid_next = out_valid_reg;
        tx_byte_next   = tx_byte_reg;
        tx_last_next   = tx_last_reg;
        persist_next   = persist_reg;

        if (q_pop)
        begin
            busy_next = 1'b1;
            k_next    = 4'd0;
            cmd_next  = q_head.cmd;
            size_next = head_size;
            if (q_head.cmd[0])
            begin
                val_next     = new_val;
                changed_next = (new_val != old_val);
                case (q_head.cmd)
                    CMD_SET_ADDR0:  addr0_next  = new_val[31:0];
                    CMD_SET_ADDR1:  addr1_next  = new_val[31:0];
                    CMD_SET_PREFIX: prefix_next = new_val;
                    default:        chan_next   = new_val[7:0];
                endcase
            end
            else
            begin
                val_next     = old_val;
                changed_next = 1'b0;
            end
        end

        if (out_load)
        begin
            out_valid_next = busy_reg;
            tx_last_next   = 1'b0;
            persist_next   = 1'b0;
            if (busy_reg)
            begin
                k_next = k_reg + 4'd1;
                if (k_reg == 4'd0)
                begin
                    tx_byte_next = HDR_BYTE;
                end
                else if (k_reg == 4'd1)
                begin
                    tx_byte_next = {4'd0, size_reg + 4'd1};
                end
                else if (k_reg == 4'd2)
                begin
                    tx_byte_next = {5'd0, cmd_reg};
                end
                else if (k_reg == last_k)
                begin
                    tx_byte_next = TAIL_BYTE;
                    tx_last_next = 1'b1;
                    persist_next = changed_reg;
                    busy_next    = 1'b0;
                end
                else
                begin
                    tx_byte_next = val_reg[7:0];
                    val_next     = {8'd0, val_reg[63:8]};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr0_reg     <= '0;
            addr1_reg     <= '0;
            prefix_reg    <= '0;
            chan_reg      <= '0;
            busy_reg      <= 1'b0;
            k_reg         <= 4'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            addr0_reg     <= addr0_next;
            addr1_reg     <= addr1_next;
            prefix_reg    <= prefix_next;
            chan_reg      <= chan_next;
            busy_reg      <= busy_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        size_reg    <= size_next;
        val_reg     <= val_next;
        changed_reg <= changed_next;
        tx_byte_reg <= tx_byte_next;
        tx_last_reg <= tx_last_next;
        persist_reg <= persist_next;
    end

endmodule

`default_nettype wire
